// ===== design/bpa_pkg.sv =====
package bpa_pkg;

    // Bitmap words are 64 pages wide; a run never exceeds one word.
    localparam int WORD_W     = 64;
    localparam int WORD_IDX_W = 6;
    // Width of a validated page count (1 to 64).
    localparam int RUN_W      = 7;
    // Number of doubling levels in the run detector (runs of 1 to 64).
    localparam int LVL_N      = 7;

    localparam int PAGE_W     = 20;
    localparam int POOL_W     = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_POOL_PAGES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIRT_BASE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHYS_BASE  = 2'd2;

    localparam logic [POOL_W-1:0] POOL_PAGES_RESET = 13'd3840;
    localparam logic [PAGE_W-1:0] VIRT_BASE_RESET  = 20'd786688;
    localparam logic [PAGE_W-1:0] PHYS_BASE_RESET  = 20'd512;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_COUNT = 2'd1;
    localparam logic [1:0] STATUS_NO_RUN    = 2'd2;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic [11:0] page_count;
        logic        user_pool;
    } req_t;

    typedef struct packed {
        logic [PAGE_W-1:0] virtual_page;
        logic [PAGE_W-1:0] physical_page;
        logic [1:0]        status;
        logic              last;
    } result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_V_MASK,
        ST_V_EVAL,
        ST_V_MARK_HI,
        ST_V_MARK_LO,
        ST_P_LOAD,
        ST_P_PICK,
        ST_ERR
    } state_t;

endpackage

// ===== design/bpa_ram.sv =====
module bpa_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bitmap_page_allocator_top.sv =====
// Bitmap page allocator. Each request transfer asks for page_count consecutive
// pages of the kernel pool. The block finds the lowest run of that many free
// virtual pages (first fit), marks it used, and then gives each page of the run,
// in order, the lowest free physical page, one result transfer per page; the
// final result of a request carries last. A count of zero or above MAX_RUN,
// a user-pool request, or a missing virtual run produces a single error result.
// If the physical pool runs dry midway, the pages already paired are reported
// with status ok and one error result with status exhausted closes the request;
// nothing taken so far is given back. Both free maps live in 64-bit-wide
// synchronous RAMs, one row per 64 pages. The virtual scan reads and then
// evaluates each row, from row 0 up to the row holding the first fitting run (at
// most the pool's last row, 60 rows at the default pool size); marking writes the
// part of the run in the current row and then the part in the previous row; the
// physical search starts at the lowest row that may still hold a free page, loads
// each row visited and then picks from it, and hands out a page whenever the
// result register can take one. After reset the block runs a clearing pass of one
// row per cycle (64 rows at the default size of 4096 pages) before it takes its
// first request; configuration writes are taken during that pass as at any other
// time.
module bitmap_page_allocator_top #(
    parameter int PAGES   = 4096,
    parameter int MAX_RUN = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  bpa_pkg::req_t                        s_data,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output bpa_pkg::result_t                     m_data,

    input  logic                                 cfg_we,
    input  logic [bpa_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    import bpa_pkg::*;

    // Map geometry: rows of 64 pages, enough rows to cover PAGES.
    localparam int ROWS  = (PAGES + WORD_W - 1) / WORD_W;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LIM_W = $clog2(ROWS * WORD_W + 1);
    localparam int WIN_W = 2 * WORD_W;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Pages of a row that lie inside the pool; bits at or above the limit
    // count as used.
    function automatic logic [WORD_W-1:0] row_mask(input logic [RW-1:0] row,
                                                   input logic [LIM_W-1:0] lim);
        logic [LIM_W:0]      base;
        logic [LIM_W:0]      top;
        logic [LIM_W:0]      diff;
        logic [WORD_W-1:0]   m;
        base = (LIM_W+1)'({row, {WORD_IDX_W{1'b0}}});
        top  = base + (LIM_W+1)'(WORD_W);
        diff = {1'b0, lim} - base;
        if ({1'b0, lim} >= top) begin
            m = '1;
        end else if ({1'b0, lim} <= base) begin
            m = '0;
        end else begin
            m = ~({WORD_W{1'b1}} << diff[WORD_IDX_W-1:0]);
        end
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] lowest_onehot(input logic [WORD_W-1:0] v);
        return v & (~v + 1'b1);
    endfunction

    function automatic logic [WORD_IDX_W-1:0] onehot_index(input logic [WORD_W-1:0] oh);
        logic [WORD_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (oh[i]) begin
                idx = idx | WORD_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------

    state_t state_reg, state_next;

    logic [POOL_W-1:0]     pool_pages_reg;
    logic [PAGE_W-1:0]     virt_base_reg;
    logic [PAGE_W-1:0]     phys_base_reg;

    logic [RUN_W-1:0]      n_reg, n_next;
    logic [2:0]            klog_reg, klog_next;
    logic [WORD_IDX_W-1:0] dshift_reg, dshift_next;
    logic [1:0]            err_status_reg, err_status_next;

    logic [RW-1:0]         row_reg, row_next;
    logic [RW-1:0]         prow_reg, prow_next;
    logic [RW-1:0]         hint_reg, hint_next;

    logic [WORD_W-1:0]     prev_free_reg, prev_free_next;
    logic [WORD_W-1:0]     prev_raw_reg, prev_raw_next;
    logic [WORD_W-1:0]     cur_raw_reg, cur_raw_next;
    logic [WORD_W-1:0]     cur_free_reg, cur_free_next;
    logic [WIN_W-1:0]      psel_reg, psel_next;
    logic [WORD_IDX_W-1:0] hit_pos_reg, hit_pos_next;
    logic [WORD_W-1:0]     mask_lo_reg, mask_lo_next;
    logic [PAGE_W-1:0]     vpage_reg, vpage_next;
    logic [WORD_IDX_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0]     pword_reg, pword_next;

    logic                  m_valid_reg, m_valid_next;
    result_t               m_data_reg, m_data_next;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------

    logic              v_we, p_we;
    logic [RW-1:0]     v_waddr, p_waddr;
    logic [WORD_W-1:0] v_wdata, p_wdata;
    logic [WORD_W-1:0] v_rdata, p_rdata;

    // Read addresses follow the next row so that the data arrives in the
    // cycle that looks at that row.
    bpa_ram #(.WIDTH(WORD_W), .DEPTH(ROWS), .ADDR_W(RW)) u_virt_map (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (row_next),
        .rdata (v_rdata)
    );

    bpa_ram #(.WIDTH(WORD_W), .DEPTH(ROWS), .ADDR_W(RW)) u_phys_map (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (prow_next),
        .rdata (p_rdata)
    );

    // ------------------------------------------------------------------
    // Shared conditions
    // ------------------------------------------------------------------

    logic [LIM_W-1:0]      limit;
    logic [LIM_W-1:0]      limit_m1;
    logic [RW-1:0]         last_row;
    logic                  accept;
    logic                  bad_count;
    logic                  out_free;
    logic                  last_page;
    logic [2:0]            klog_in;
    logic [WORD_IDX_W-1:0] dshift_in;

    // Effective pool size is the register value capped at the map size.
    assign limit    = (int'(pool_pages_reg) > PAGES) ? LIM_W'(PAGES) : LIM_W'(pool_pages_reg);
    assign limit_m1 = limit - 1'b1;
    assign last_row = limit_m1[RW+WORD_IDX_W-1:WORD_IDX_W];

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign bad_count = (s_data.page_count == '0) || (int'(s_data.page_count) > MAX_RUN);
    // The result register can take a new result when it is empty or being drained.
    assign out_free  = !m_valid_reg || m_ready;
    assign last_page = ((RUN_W'(count_reg) + 1'b1) == n_reg);

    // A run of n free pages is covered by two overlapping runs of 2^k pages,
    // with 2^k <= n < 2^(k+1), set apart by n - 2^k.
    always_comb begin
        logic [RUN_W-1:0] n_in;
        logic [RUN_W-1:0] pow;
        n_in    = s_data.page_count[RUN_W-1:0];
        klog_in = '0;
        for (int i = 0; i < RUN_W; i++) begin
            if (n_in[i]) begin
                klog_in = 3'(i);
            end
        end
        pow       = RUN_W'(1) << klog_in;
        dshift_in = WORD_IDX_W'(n_in - pow);
    end

    // Virtual run detector. The window holds the free bits of the previous row
    // below those of the current row, so a run may cross a row boundary.
    logic [WORD_W-1:0] cur_free;
    logic [WIN_W-1:0]  lvl [0:LVL_N-1];
    logic [WIN_W-1:0]  hit;
    logic [WORD_W-1:0] hit_hi;
    logic              v_found;
    logic [WORD_IDX_W-1:0] v_pos;

    assign cur_free = ~v_rdata & row_mask(row_reg, limit);

    always_comb begin
        lvl[0] = {cur_free, prev_free_reg};
        for (int i = 0; i < LVL_N - 1; i++) begin
            lvl[i+1] = lvl[i] & (lvl[i] << (1 << i));
        end
    end

    assign hit     = psel_reg & (psel_reg << dshift_reg);
    assign hit_hi  = hit[WIN_W-1:WORD_W];
    assign v_found = |hit_hi;
    assign v_pos   = onehot_index(lowest_onehot(hit_hi));

    // Mask of the found run in window coordinates.
    logic [RUN_W-1:0] run_end;
    logic [RUN_W-1:0] run_start;
    logic [WIN_W-1:0] run_mask;

    assign run_end   = {1'b1, hit_pos_reg};
    assign run_start = run_end + 1'b1 - n_reg;
    assign run_mask  = ~({WIN_W{1'b1}} << n_reg) << run_start;

    // Physical pick: lowest free page of the held row.
    logic [WORD_W-1:0]     p_free;
    logic                  p_any;
    logic [WORD_W-1:0]     p_bit;
    logic [WORD_IDX_W-1:0] p_pos;

    assign p_free = ~pword_reg & row_mask(prow_reg, limit);
    assign p_any  = |p_free;
    assign p_bit  = lowest_onehot(p_free);
    assign p_pos  = onehot_index(p_bit);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (row_reg == RW'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (bad_count || s_data.user_pool || (limit == '0)) begin
                        state_next = ST_ERR;
                    end else begin
                        state_next = ST_V_MASK;
                    end
                end
            end
            ST_V_MASK: begin
                state_next = ST_V_EVAL;
            end
            ST_V_EVAL: begin
                if (v_found) begin
                    state_next = ST_V_MARK_HI;
                end else if (row_reg >= last_row) begin
                    state_next = ST_ERR;
                end else begin
                    state_next = ST_V_MASK;
                end
            end
            ST_V_MARK_HI: begin
                state_next = ST_V_MARK_LO;
            end
            ST_V_MARK_LO: begin
                state_next = ST_P_LOAD;
            end
            ST_P_LOAD: begin
                state_next = ST_P_PICK;
            end
            ST_P_PICK: begin
                if (p_any) begin
                    if (out_free && last_page) begin
                        state_next = ST_IDLE;
                    end
                end else if (prow_reg >= last_row) begin
                    state_next = ST_ERR;
                end else begin
                    state_next = ST_P_LOAD;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath, memory ports and results
    // ------------------------------------------------------------------

    logic    out_load;
    result_t out_data;

    always_comb begin
        n_next          = n_reg;
        klog_next       = klog_reg;
        dshift_next     = dshift_reg;
        err_status_next = err_status_reg;
        row_next        = row_reg;
        prow_next       = prow_reg;
        hint_next       = hint_reg;
        prev_free_next  = prev_free_reg;
        prev_raw_next   = prev_raw_reg;
        cur_raw_next    = cur_raw_reg;
        cur_free_next   = cur_free_reg;
        psel_next       = psel_reg;
        hit_pos_next    = hit_pos_reg;
        mask_lo_next    = mask_lo_reg;
        vpage_next      = vpage_reg;
        count_next      = count_reg;
        pword_next      = pword_reg;

        v_we    = 1'b0;
        v_waddr = row_reg;
        v_wdata = '0;
        p_we    = 1'b0;
        p_waddr = prow_reg;
        p_wdata = '0;

        out_load = 1'b0;
        out_data = '0;

        case (state_reg)
            ST_CLEAR: begin
                // One row of each map per cycle.
                v_we    = 1'b1;
                p_we    = 1'b1;
                p_waddr = row_reg;
                if (row_reg == RW'(ROWS - 1)) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_next          = s_data.page_count[RUN_W-1:0];
                    klog_next       = klog_in;
                    dshift_next     = dshift_in;
                    err_status_next = bad_count ? STATUS_BAD_COUNT : STATUS_NO_RUN;
                    row_next        = '0;
                    prev_free_next  = '0;
                    prev_raw_next   = '0;
                    count_next      = '0;
                end
            end
            ST_V_MASK: begin
                cur_raw_next  = v_rdata;
                cur_free_next = cur_free;
                psel_next     = lvl[klog_reg];
            end
            ST_V_EVAL: begin
                if (v_found) begin
                    hit_pos_next = v_pos;
                end else begin
                    prev_free_next = cur_free_reg;
                    prev_raw_next  = cur_raw_reg;
                    if (row_reg < last_row) begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            ST_V_MARK_HI: begin
                // The run ends in the current row; the part that falls in the
                // previous row is written next cycle.
                v_we         = 1'b1;
                v_wdata      = cur_raw_reg | run_mask[WIN_W-1:WORD_W];
                mask_lo_next = run_mask[WORD_W-1:0];
                vpage_next   = virt_base_reg + PAGE_W'({row_reg, hit_pos_reg})
                             + 1'b1 - PAGE_W'(n_reg);
            end
            ST_V_MARK_LO: begin
                v_we      = |mask_lo_reg;
                v_waddr   = row_reg - 1'b1;
                v_wdata   = prev_raw_reg | mask_lo_reg;
                prow_next = hint_reg;
            end
            ST_P_LOAD: begin
                pword_next = p_rdata;
            end
            ST_P_PICK: begin
                if (p_any) begin
                    if (out_free) begin
                        out_load               = 1'b1;
                        out_data.virtual_page  = vpage_reg;
                        out_data.physical_page = phys_base_reg + PAGE_W'({prow_reg, p_pos});
                        out_data.status        = STATUS_OK;
                        out_data.last          = last_page;
                        pword_next             = pword_reg | p_bit;
                        vpage_next             = vpage_reg + 1'b1;
                        count_next             = count_reg + 1'b1;
                        if (last_page) begin
                            p_we    = 1'b1;
                            p_wdata = pword_reg | p_bit;
                        end
                    end
                end else begin
                    // Row used up inside the pool: write it back and move on, or report exhaustion at the last row.
                    p_we    = 1'b1;
                    p_wdata = pword_reg;
                    if (prow_reg >= last_row) begin
                        err_status_next = STATUS_EXHAUSTED;
                    end else begin
                        prow_next = prow_reg + 1'b1;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_data.status = err_status_reg;
                    out_data.last   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Physical pages are never freed, so a full row stays full and the
        // search can start past it from then on.
        if (p_we && (state_reg == ST_P_PICK) && (p_wdata == '1) &&
            (prow_reg == hint_reg) && (hint_reg != RW'(ROWS - 1))) begin
            hint_next = hint_reg + 1'b1;
        end
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = out_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Sequential logic
    // ------------------------------------------------------------------

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            row_reg        <= '0;
            prow_reg       <= '0;
            hint_reg       <= '0;
            m_valid_reg    <= 1'b0;
            pool_pages_reg <= POOL_PAGES_RESET;
            virt_base_reg  <= VIRT_BASE_RESET;
            phys_base_reg  <= PHYS_BASE_RESET;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            prow_reg    <= prow_next;
            hint_reg    <= hint_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_POOL_PAGES: pool_pages_reg <= cfg_wdata[POOL_W-1:0];
                    CFG_VIRT_BASE:  virt_base_reg  <= cfg_wdata[PAGE_W-1:0];
                    CFG_PHYS_BASE:  phys_base_reg  <= cfg_wdata[PAGE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        klog_reg       <= klog_next;
        dshift_reg     <= dshift_next;
        err_status_reg <= err_status_next;
        prev_free_reg  <= prev_free_next;
        prev_raw_reg   <= prev_raw_next;
        cur_raw_reg    <= cur_raw_next;
        cur_free_reg   <= cur_free_next;
        psel_reg       <= psel_next;
        hit_pos_reg    <= hit_pos_next;
        mask_lo_reg    <= mask_lo_next;
        vpage_reg      <= vpage_next;
        count_reg      <= count_next;
        pword_reg      <= pword_next;
        m_data_reg     <= m_data_next;
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import bpa_pkg::*;

    // Geometry of the block under test. Both values are handed to the instance so the
    // shadow maps below always match the hardware maps.
    localparam int PAGE_TOTAL = 4096;
    localparam int RUN_MAX    = 64;

    // The shadow keeps both free maps in one array. These name the two rows.
    localparam int VIRT_MAP = 0;
    localparam int PHYS_MAP = 1;

    // The port is two bits wide, so index 3 exists but selects no register.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam int RANDOM_PER_PHASE = 170;
    localparam int LONG_HOLD_CYCLES = 1500;
    localparam int DRAIN_CYCLES     = 300;
    // The timeout assumes the slowest legal run and then adds a wide margin on top.
    localparam int TIMEOUT_CYCLES   = 4_000_000;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    req_t             s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    result_t          m_data;
    logic             cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Idle rates are percentages per cycle. The main sequence sets them for each phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // When the main sequence raises this flag, the receiver holds off for one long stretch.
    bit          long_hold_armed = 1'b0;

    // Shadow of the allocator. It tracks both free maps and the three registers. Each
    // accepted request turns into the page pairs that the block should report, and those
    // pairs wait in order until the matching result transfers arrive.
    class allocator_shadow;
        bit          page_used [2][PAGE_TOTAL];
        // Pages are never freed, so every bit below free_floor stays used for good.
        // A search can therefore start at the floor and still give the same answer as
        // a search from bit 0.
        int          free_floor [2];
        logic [12:0] pool_pages;
        logic [19:0] virt_base;
        logic [19:0] phys_base;
        result_t     pending_pairs [$];
        int unsigned mismatches;

        function new();
            foreach (page_used[m, i]) page_used[m][i] = 1'b0;
            free_floor[VIRT_MAP] = 0;
            free_floor[PHYS_MAP] = 0;
            pool_pages = POOL_PAGES_RESET;
            virt_base  = VIRT_BASE_RESET;
            phys_base  = PHYS_BASE_RESET;
            mismatches = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [19:0] value);
            case (idx)
                CFG_POOL_PAGES: pool_pages = value[12:0];
                CFG_VIRT_BASE:  virt_base  = value;
                CFG_PHYS_BASE:  phys_base  = value;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_pairs.size();
        endfunction

        // First fit: find the lowest run of n free bits that lies wholly below limit.
        function bit lowest_run(int map, int limit, int n, output int start);
            int run;
            run   = 0;
            start = 0;
            for (int i = free_floor[map]; i < limit; i++) begin
                if (page_used[map][i]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == n) begin
                        start = i + 1 - n;
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void mark_used(int map, int idx);
            page_used[map][idx] = 1'b1;
            while (free_floor[map] < PAGE_TOTAL && page_used[map][free_floor[map]])
                free_floor[map]++;
        endfunction

        function void push_error(logic [1:0] code);
            result_t res;
            res = '0;
            res.status = code;
            res.last   = 1'b1;
            pending_pairs.push_back(res);
        endfunction

        function void take_request(req_t r);
            int      n;
            int      limit;
            int      vstart;
            int      pidx;
            result_t res;
            n     = r.page_count;
            limit = (pool_pages > PAGE_TOTAL) ? PAGE_TOTAL : int'(pool_pages);
            if (n == 0 || n > RUN_MAX) begin
                push_error(STATUS_BAD_COUNT);
                return;
            end
            if (r.user_pool || !lowest_run(VIRT_MAP, limit, n, vstart)) begin
                push_error(STATUS_NO_RUN);
                return;
            end
            for (int k = 0; k < n; k++) mark_used(VIRT_MAP, vstart + k);
            for (int k = 0; k < n; k++) begin
                // The virtual run is kept even when the physical pool runs dry here.
                if (!lowest_run(PHYS_MAP, limit, 1, pidx)) begin
                    push_error(STATUS_EXHAUSTED);
                    return;
                end
                mark_used(PHYS_MAP, pidx);
                res.virtual_page  = virt_base + 20'(vstart + k);
                res.physical_page = phys_base + 20'(pidx);
                res.status        = STATUS_OK;
                res.last          = (k == n - 1);
                pending_pairs.push_back(res);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_pairs.size() == 0) begin
                $error("result transfer with nothing pending: %p", got);
                mismatches++;
                return;
            end
            want = pending_pairs.pop_front();
            if (got.virtual_page !== want.virtual_page) begin
                $error("virtual_page expected %h actual %h", want.virtual_page,
                       got.virtual_page);
                mismatches++;
            end
            if (got.physical_page !== want.physical_page) begin
                $error("physical_page expected %h actual %h", want.physical_page,
                       got.physical_page);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last expected %0d actual %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    allocator_shadow shadow = new();

    bitmap_page_allocator_top #(
        .PAGES   (PAGE_TOTAL),
        .MAX_RUN (RUN_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // The clock period is 12 time units.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Every result transfer is checked at the rising edge that accepts it. The values
    // read here are the ones from before the edge, so they are the same ones the block
    // saw when it accepted the transfer.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) shadow.check_result(m_data);
    end

    // The receiver changes m_ready at each falling edge. It does so at random according
    // to the current idle rate. When the long hold is armed, it instead keeps m_ready low
    // for one long stretch while the sender keeps offering requests. That stretch
    // fills every internal buffer so the block has to push back on its input side.
    initial begin
        bit long_hold_done;
        long_hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_armed && !long_hold_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                long_hold_done = 1'b1;
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // This task offers one request and returns at the rising edge that accepts it. It
    // leaves s_valid high, so the next request can follow in the very next cycle. Idle
    // gaps come before the transfer, one falling edge at a time, which means s_valid
    // never gets two assignments in the same time step.
    task automatic send_request(input req_t r);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shadow.take_request(r);
    endtask

    // Registers change only while the block is idle. This task withdraws the request
    // channel, waits until every pending result has come back, and then writes the
    // register. Because every request produces at least one result, an empty shadow
    // queue means the block has nothing left in flight.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (shadow.outstanding() != 0) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        shadow.write_register(idx, value);
    endtask

    function automatic req_t make_request(int count, bit user);
        req_t r;
        r.page_count = 12'(count);
        r.user_pool  = user;
        return r;
    endfunction

    // The random mix is mostly small kernel requests that succeed, with some large runs.
    // Bad counts and user pool requests come in as occasional noise. Small counts spread
    // the fixed supply of pages over the whole run, because pages are never freed.
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        r.user_pool = 1'b0;
        if (pick < 8) begin
            r.page_count = 12'($urandom_range(RUN_MAX + 1, 4095));
        end else if (pick < 10) begin
            r.page_count = '0;
        end else if (pick < 18) begin
            r.user_pool  = 1'b1;
            r.page_count = 12'($urandom);
        end else if (pick < 28) begin
            r.page_count = 12'($urandom_range(5, RUN_MAX));
        end else begin
            r.page_count = 12'($urandom_range(1, 4));
        end
        return r;
    endfunction

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The first requests use the reset settings. They cover the smallest and largest
        // legal counts and the count just past the limit. They also cover the widest
        // count field, which sets the high bits of page_count. A user pool request is
        // refused with either count. A zero count is reported as a bad count even when
        // it also targets the user pool.
        send_request(make_request(1, 1'b0));
        send_request(make_request(RUN_MAX, 1'b0));
        send_request(make_request(2, 1'b0));
        send_request(make_request(1, 1'b1));
        send_request(make_request(RUN_MAX, 1'b1));
        send_request(make_request(0, 1'b0));
        send_request(make_request(RUN_MAX + 1, 1'b0));
        send_request(make_request(4095, 1'b0));
        send_request(make_request(12'hFC0, 1'b0));
        send_request(make_request(0, 1'b1));
        send_request(make_request(RUN_MAX, 1'b0));
        send_request(make_request(3, 1'b0));

        // The first 134 pages are in use now. With an empty pool, every request finds
        // no virtual run. A pool of 140 pages leaves a gap of six, so a 64 page request
        // does not fit, a 6 page request fits exactly up to the pool's end, and after
        // that the pool is full.
        write_register(CFG_POOL_PAGES, 20'd0);
        send_request(make_request(1, 1'b0));
        write_register(CFG_POOL_PAGES, 20'd140);
        send_request(make_request(RUN_MAX, 1'b0));
        send_request(make_request(6, 1'b0));
        send_request(make_request(1, 1'b0));

        // All bits set in the write data give a pool size above the map. The block must
        // clip that to the map size. A write to the unmapped index must change nothing.
        // Bases at the top of the page range make both page numbers wrap at 20 bits.
        write_register(CFG_POOL_PAGES, 20'hFFFFF);
        write_register(CFG_UNMAPPED, 20'h00007);
        write_register(CFG_VIRT_BASE, 20'hFFFFF);
        write_register(CFG_PHYS_BASE, 20'hFFFF0);
        send_request(make_request(20, 1'b0));
        write_register(CFG_VIRT_BASE, 20'd0);
        write_register(CFG_PHYS_BASE, 20'd0);
        send_request(make_request(1, 1'b0));

        // There are three random phases. The receiver idles more in the first, the sender
        // idles more in the second, and in the third neither idles and the long hold
        // fires. Each phase starts from new register settings, and the pool grows
        // with every phase so that later requests still find free pages.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    write_register(CFG_POOL_PAGES, 20'd2000);
                    write_register(CFG_VIRT_BASE, 20'($urandom_range(0, 20'hFFFFF)));
                    send_idle_pct = 23;
                    recv_idle_pct = 68;
                end
                1: begin
                    write_register(CFG_POOL_PAGES, 20'd3500);
                    write_register(CFG_VIRT_BASE, 20'hFFFFF);
                    send_idle_pct = 68;
                    recv_idle_pct = 23;
                end
                default: begin
                    write_register(CFG_POOL_PAGES, 20'h01FFF);
                    write_register(CFG_VIRT_BASE, 20'($urandom_range(0, 20'hFFFFF)));
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    long_hold_armed = 1'b1;
                end
            endcase
            write_register(CFG_PHYS_BASE, 20'($urandom_range(0, 20'hFFFFF)));
            repeat (RANDOM_PER_PHASE) send_request(random_request());
        end

        // Withdraw the request channel and wait until every result is back. Then leave
        // the block a while longer, so that any extra result it sends gets caught.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (shadow.outstanding() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (shadow.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // If a handshake hangs, this ends the run.
    initial begin
        #(12 * TIMEOUT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bpa_pkg.sv
design/bpa_ram.sv
design/bitmap_page_allocator_top.sv
tb/testbench.sv
